>>> design/xor_checksum_link_monitor_core_assert.svh
// ----------------------------------------------------------------------------
// XOR checksum link monitor assertion macros
// Short forms for the concurrent assertions in the port checker.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKSUM_LINK_MONITOR_CORE_ASSERT_SVH
`define XOR_CHECKSUM_LINK_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XCLM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xclm: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define XCLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xclm: next-cycle check failed");

// Next-cycle implication that is also checked through reset.
`define XCLM_ASSERT_RESET_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("xclm: reset check failed");

`endif

>>> design/xclm_pkg.sv
// ----------------------------------------------------------------------------
// XOR checksum link monitor package
// Shared constants, command types and helper functions.
// ----------------------------------------------------------------------------
package xclm_pkg;

  // Block dimensions.
  localparam int WINDOW_LEN  = 10;
  localparam int NUM_BOARDS  = 2;
  localparam int BOARD_W     = 1;
  localparam int WORD_W      = 32;
  localparam int COUNT_W     = 4;
  localparam int THRESH_W    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0]   CHECKSUM_OFFSET = 32'h0000_00AA;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 4'd5;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 4'd15;

  // Request codes carried on the input transfer.
  localparam logic [1:0] REQ_TX_WORD  = 2'd0;
  localparam logic [1:0] REQ_RX_WORD  = 2'd1;
  localparam logic [1:0] REQ_CHECKSUM = 2'd2;

  // Result kinds.
  localparam logic RESULT_TX_CHECKSUM = 1'b0;
  localparam logic RESULT_RX_CHECK    = 1'b1;

  typedef logic [WINDOW_LEN-1:0] window_t;
  typedef logic [BOARD_W-1:0]    board_t;
  typedef logic [WORD_W-1:0]     word_t;

  // Operations that the front end hands to the back end.
  typedef enum logic [1:0] {
    OP_TX_ACC,
    OP_TX_EMIT,
    OP_RX_ACC,
    OP_CHECK
  } op_t;

  typedef struct packed {
    op_t    op;
    board_t board;
    word_t  word;
    logic   tend;
  } cmd_t;

  // Number of errored transfers held in the window.
  function automatic int win_count(window_t w);
    int n;
    n = 0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      n = n + int'(w[i]);
    end
    return n;
  endfunction

  // Error count as reported, saturated to the field width.
  function automatic logic [COUNT_W-1:0] count_field(int n);
    logic [COUNT_W-1:0] c;
    if (n > int'(COUNT_MAX)) begin
      c = COUNT_MAX;
    end else begin
      c = COUNT_W'(n);
    end
    return c;
  endfunction

endpackage

>>> design/xor_checksum_link_monitor_core.sv
// ----------------------------------------------------------------------------
// XOR checksum link monitor core
// An accepted transfer is held in the command queue and its result in the output
// register, so out_tvalid is registered behind both.
// Throughput: one input transfer per cycle while the queue has room, limited by the
// one-command-per-cycle back end and the two-entry command queue.
// Reset (rst_n low, synchronous) empties the queue and output register, clears
// the accumulators, error window and stop latch, and sets the threshold to 5.
// ----------------------------------------------------------------------------
module xor_checksum_link_monitor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // trip_threshold
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // data_word [31:0], transfer_end [32], zero fill
  input  logic [2:0]  in_tuser,      // req_type [1:0], board [2]
  input  logic        in_tlast,      // payload_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // checksum_value [31:0], frame_ok [32],
                                     // window_errors [36:33], link_stopped [37], zero fill
  output logic [0:0]  out_tuser      // result_kind
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  xclm_pkg::cmd_t push_cmd;
  xclm_pkg::cmd_t head_cmd;

  // Request decode.
  xclm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Command queue.
  xclm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd)
  );

  // Checksum and link state execution.
  xclm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

>>> design/xclm_front.sv
// ----------------------------------------------------------------------------
// XOR checksum link monitor front end
// Decodes each input transfer into a back-end command and drops requests
// that can never have an effect.
// ----------------------------------------------------------------------------
module xclm_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // data_word [31:0], transfer_end [32], zero fill
  input  logic [2:0]        in_tuser,   // req_type [1:0], board [2]
  input  logic              in_tlast,   // payload_last
  input  logic              q_full,
  output logic              q_push,
  output xclm_pkg::cmd_t    q_cmd
);

  logic [1:0]       req_type;
  xclm_pkg::board_t board;
  logic             known;

  assign req_type = in_tuser[1:0];
  assign board    = in_tuser[2];

  // Accept whenever the queue has room; dropped requests still complete.
  assign in_tready = !q_full;

  // Classify the request.
  always_comb begin
    known          = 1'b1;
    q_cmd.op       = xclm_pkg::OP_TX_ACC;
    q_cmd.board    = board;
    q_cmd.word     = in_tdata[31:0];
    q_cmd.tend     = in_tdata[32];
    case (req_type)
      xclm_pkg::REQ_TX_WORD: begin
        q_cmd.op = in_tlast ? xclm_pkg::OP_TX_EMIT : xclm_pkg::OP_TX_ACC;
      end
      xclm_pkg::REQ_RX_WORD: begin
        q_cmd.op = xclm_pkg::OP_RX_ACC;
      end
      xclm_pkg::REQ_CHECKSUM: begin
        q_cmd.op = xclm_pkg::OP_CHECK;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    if (int'(board) >= xclm_pkg::NUM_BOARDS) begin
      known = 1'b0;
    end
  end

  assign q_push = in_tvalid && in_tready && known;

endmodule

>>> design/xclm_queue.sv
// ----------------------------------------------------------------------------
// XOR checksum link monitor command queue
// Small FIFO between front and back end so each side can stall on its own.
// ----------------------------------------------------------------------------
module xclm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xclm_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output xclm_pkg::cmd_t q_cmd
);

  localparam int PTR_W = (xclm_pkg::QUEUE_DEPTH > 1) ? $clog2(xclm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(xclm_pkg::QUEUE_DEPTH + 1);

  xclm_pkg::cmd_t   entry_r [xclm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(xclm_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == xclm_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == xclm_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/xclm_back.sv
// ----------------------------------------------------------------------------
// XOR checksum link monitor back end
// Runs a command per cycle, unless its result must wait, on the checksum
// accumulators, error window and stop latch; registers the output result.
// ----------------------------------------------------------------------------
module xclm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [xclm_pkg::THRESH_W-1:0]   cfg_wr_data,
  input  logic                            q_valid,
  input  xclm_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata,
  output logic [0:0]                      out_tuser
);

  xclm_pkg::word_t   tx_acc_r [xclm_pkg::NUM_BOARDS];
  xclm_pkg::word_t   rx_acc_r [xclm_pkg::NUM_BOARDS];
  xclm_pkg::word_t   acc_nxt;
  logic              terr_r, terr_nxt;
  xclm_pkg::window_t win_r, win_nxt;
  logic              stop_r, stop_nxt;
  logic [xclm_pkg::THRESH_W-1:0] thresh_r;

  logic              out_valid_r;
  xclm_pkg::word_t   out_sum_r, out_sum_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [xclm_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic              out_stop_r;

  xclm_pkg::word_t   tx_mix;
  xclm_pkg::word_t   rx_sum;
  logic              chk_ok;
  logic              chk_err;
  logic              emits;
  logic              slot_free;
  int                cnt_new;

  // Datapath terms for the command at the head of the queue.
  assign tx_mix  = tx_acc_r[q_cmd.board] ^ q_cmd.word;
  assign rx_sum  = rx_acc_r[q_cmd.board] + xclm_pkg::CHECKSUM_OFFSET;
  assign chk_ok  = (rx_sum == q_cmd.word);
  assign chk_err = terr_r || !chk_ok;

  // A command is taken when it needs no result slot or the slot frees up.
  assign emits     = !stop_r && (q_cmd.op == xclm_pkg::OP_TX_EMIT ||
                                 q_cmd.op == xclm_pkg::OP_CHECK);
  assign slot_free = !out_valid_r || out_tready;
  assign q_pop     = q_valid && (!emits || slot_free);

  // Window, latch and result computation.
  always_comb begin
    acc_nxt      = '0;
    terr_nxt     = terr_r;
    win_nxt      = win_r;
    stop_nxt     = stop_r;
    cnt_new      = xclm_pkg::win_count(win_r);
    out_sum_nxt  = out_sum_r;
    out_kind_nxt = out_kind_r;
    out_ok_nxt   = out_ok_r;
    out_cnt_nxt  = out_cnt_r;
    case (q_cmd.op)
      xclm_pkg::OP_TX_ACC: begin
        acc_nxt = tx_mix;
      end
      xclm_pkg::OP_TX_EMIT: begin
        acc_nxt      = '0;
        out_sum_nxt  = tx_mix + xclm_pkg::CHECKSUM_OFFSET;
        out_kind_nxt = xclm_pkg::RESULT_TX_CHECKSUM;
        out_ok_nxt   = 1'b0;
        out_cnt_nxt  = xclm_pkg::count_field(cnt_new);
      end
      xclm_pkg::OP_RX_ACC: begin
        acc_nxt = rx_acc_r[q_cmd.board] ^ q_cmd.word;
      end
      xclm_pkg::OP_CHECK: begin
        acc_nxt  = '0;
        terr_nxt = chk_err;
        if (q_cmd.tend) begin
          win_nxt  = (win_r << 1) | xclm_pkg::WINDOW_LEN'(chk_err);
          terr_nxt = 1'b0;
          cnt_new  = xclm_pkg::win_count(win_nxt);
          if (cnt_new >= int'(thresh_r)) begin
            stop_nxt = 1'b1;
          end
        end
        out_sum_nxt  = rx_sum;
        out_kind_nxt = xclm_pkg::RESULT_RX_CHECK;
        out_ok_nxt   = chk_ok;
        out_cnt_nxt  = xclm_pkg::count_field(cnt_new);
      end
      default: begin
        acc_nxt = '0;
      end
    endcase
  end

  // Monitor state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xclm_pkg::NUM_BOARDS; i++) begin
        tx_acc_r[i] <= '0;
        rx_acc_r[i] <= '0;
      end
      terr_r      <= 1'b0;
      win_r       <= '0;
      stop_r      <= 1'b0;
      thresh_r    <= xclm_pkg::THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (q_pop && !stop_r) begin
        if (q_cmd.op == xclm_pkg::OP_TX_ACC || q_cmd.op == xclm_pkg::OP_TX_EMIT) begin
          tx_acc_r[q_cmd.board] <= acc_nxt;
        end else begin
          rx_acc_r[q_cmd.board] <= acc_nxt;
        end
        terr_r <= terr_nxt;
        win_r  <= win_nxt;
        stop_r <= stop_nxt;
      end
      if (q_pop && emits) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (q_pop && emits) begin
      out_sum_r  <= out_sum_nxt;
      out_kind_r <= out_kind_nxt;
      out_ok_r   <= out_ok_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_stop_r <= (q_cmd.op == xclm_pkg::OP_CHECK) ? stop_nxt : 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_stop_r, out_cnt_r, out_ok_r, out_sum_r};
  assign out_tuser  = out_kind_r;

endmodule

>>> design/xclm_checker.sv
// ----------------------------------------------------------------------------
// XOR checksum link monitor port checker
// Watches the top-level ports for result consistency and reset behavior.
// ----------------------------------------------------------------------------
`include "xor_checksum_link_monitor_core_assert.svh"

module xclm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled result keeps its contents.
  `XCLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Transmit checksums never carry a frame flag or the stop flag.
  `XCLM_ASSERT_IMPLY(a_tx_flags, clk, rst_n, out_tvalid && out_tuser == xclm_pkg::RESULT_TX_CHECKSUM, out_tdata[32] == 1'b0 && out_tdata[37] == 1'b0)

  // The error count cannot exceed the window length.
  `XCLM_ASSERT_IMPLY(a_count_range, clk, rst_n, out_tvalid, int'(out_tdata[36:33]) <= xclm_pkg::WINDOW_LEN)

  // No result is presented right after reset.
  `XCLM_ASSERT_RESET_NEXT(a_reset_idle, clk, !rst_n, !out_tvalid)

endmodule

bind xor_checksum_link_monitor_core xclm_checker u_xclm_checker (.*);
